@@ src/pgl_pkg.sv @@
package pgl_pkg;

  localparam int COORD_BITS_DEF      = 12;
  localparam int ANGLE_FRAC_BITS_DEF = 16;

  // Datapath widths and step counts of the pipeline.
  localparam int CW            = 36;
  localparam int ZW            = 34;
  localparam int VW            = 30;
  localparam int CORDIC_STEPS  = 30;
  localparam int DIV_STEPS     = 48;
  localparam int SQRT_STEPS    = 29;
  localparam int SQRT_RAD_BITS = 2 * SQRT_STEPS;
  localparam int NORM_STEPS    = 5;
  localparam int RADIAL_BITS   = 24;
  localparam int DEG_PROD_BITS = 41;

  localparam logic [RADIAL_BITS-1:0] RADIAL_ONE = 24'h010000;
  localparam logic [RADIAL_BITS-1:0] RADIAL_MAX = 24'hFFFFFF;

  localparam logic [29:0] K_Q30 = 30'd652032874;
  localparam logic [30:0] G_Q30 = 31'd1768195363;

  localparam logic [31:0] TURN_QUARTER = 32'h4000_0000;
  localparam logic signed [ZW-1:0] Z_HALF = 34'sh0_8000_0000;

  // Register map, word index.
  localparam logic [2:0] REG_FRAME_WIDTH  = 3'd0;
  localparam logic [2:0] REG_FRAME_HEIGHT = 3'd1;
  localparam logic [2:0] REG_GLOBE_RADIUS = 3'd2;
  localparam logic [2:0] REG_SUN_LON      = 3'd3;
  localparam logic [2:0] REG_SUN_LAT      = 3'd4;

  localparam logic [31:0] ATAN_TABLE [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
  };

endpackage

@@ src/pgl_cordic_cell.sv @@
module pgl_cordic_cell import pgl_pkg::*; #(
  parameter int STEP   = 0,
  parameter bit VECTOR = 1'b0,
  parameter int SW     = 1
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [CW-1:0] x_in,
  input  logic signed [CW-1:0] y_in,
  input  logic signed [ZW-1:0] z_in,
  input  logic [SW-1:0]        side_in,
  output logic signed [CW-1:0] x_out,
  output logic signed [CW-1:0] y_out,
  output logic signed [ZW-1:0] z_out,
  output logic [SW-1:0]        side_out
);

  localparam logic signed [ZW-1:0] ATAN = ZW'(ATAN_TABLE[STEP]);

  logic signed [CW-1:0] xs;
  logic signed [CW-1:0] ys;
  logic                 ccw;

  assign xs = x_in >>> STEP;
  assign ys = y_in >>> STEP;
  // Rotation steps follow the residual angle, vectoring steps drive y to zero.
  assign ccw = VECTOR ? y_in[CW-1] : ~z_in[ZW-1];

  always_ff @(posedge clk) begin
    if (en) begin
      if (ccw) begin
        x_out <= x_in - ys;
        y_out <= y_in + xs;
        z_out <= z_in - ATAN;
      end else begin
        x_out <= x_in + ys;
        y_out <= y_in - xs;
        z_out <= z_in + ATAN;
      end
      side_out <= side_in;
    end
  end

endmodule

@@ src/pgl_div_cell.sv @@
module pgl_div_cell import pgl_pkg::*; #(
  parameter int DW = 28,
  parameter int SW = 1
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [DW-1:0]        rem_in,
  input  logic [DIV_STEPS-1:0] num_in,
  input  logic [DIV_STEPS-1:0] q_in,
  input  logic [DW-1:0]        dd_in,
  input  logic [SW-1:0]        side_in,
  output logic [DW-1:0]        rem_out,
  output logic [DIV_STEPS-1:0] num_out,
  output logic [DIV_STEPS-1:0] q_out,
  output logic [DW-1:0]        dd_out,
  output logic [SW-1:0]        side_out
);

  logic [DW:0] trial;
  logic        ge;

  assign trial = {rem_in, num_in[DIV_STEPS-1]};
  assign ge    = trial >= {1'b0, dd_in};

  always_ff @(posedge clk) begin
    if (en) begin
      rem_out  <= ge ? DW'(trial - {1'b0, dd_in}) : DW'(trial);
      q_out    <= {q_in[DIV_STEPS-2:0], ge};
      num_out  <= num_in << 1;
      dd_out   <= dd_in;
      side_out <= side_in;
    end
  end

endmodule

@@ src/pgl_sqrt_cell.sv @@
module pgl_sqrt_cell import pgl_pkg::*; #(
  parameter int SW = 1
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic [SQRT_RAD_BITS-1:0] rad_in,
  input  logic [SQRT_STEPS+1:0]    rem_in,
  input  logic [SQRT_STEPS-1:0]    root_in,
  input  logic [SW-1:0]            side_in,
  output logic [SQRT_RAD_BITS-1:0] rad_out,
  output logic [SQRT_STEPS+1:0]    rem_out,
  output logic [SQRT_STEPS-1:0]    root_out,
  output logic [SW-1:0]            side_out
);

  logic [SQRT_STEPS+3:0] r2;
  logic [SQRT_STEPS+3:0] trial;
  logic                  ge;

  // One result bit per cell: bring down two radicand bits, try root*4+1.
  assign r2    = {rem_in, rad_in[SQRT_RAD_BITS-1 -: 2]};
  assign trial = {2'b00, root_in, 2'b01};
  assign ge    = r2 >= trial;

  always_ff @(posedge clk) begin
    if (en) begin
      rem_out  <= ge ? (SQRT_STEPS + 2)'(r2 - trial) : (SQRT_STEPS + 2)'(r2);
      root_out <= {root_in[SQRT_STEPS-2:0], ge};
      rad_out  <= rad_in << 2;
      side_out <= side_in;
    end
  end

endmodule

@@ src/pixel_to_globe_latlong.sv @@
// Throughput: one pixel per cycle; the whole pipeline advances together and
// holds while a result waits at the output register.
// The divider (48 cells), square root (29 cells) and three CORDIC chains
// (30 cells each) set the depth. Synchronous reset clears the pipeline
// valid bits and loads the register defaults; no clearing pass is needed.
module pixel_to_globe_latlong import pgl_pkg::*; #(
  parameter int COORD_BITS      = COORD_BITS_DEF,
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [4:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [COORD_BITS-1:0]        pixel_x,
  input  logic [COORD_BITS-1:0]        pixel_y,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [ANGLE_FRAC_BITS+8:0]   longitude,
  output logic [ANGLE_FRAC_BITS+7:0]   latitude,
  output logic [RADIAL_BITS-1:0]       radial_distance
);

  localparam int RGW  = COORD_BITS + 1;
  localparam int AW   = COORD_BITS + 2;
  localparam int SQW  = 2 * COORD_BITS + 4;
  localparam int SS   = 27 - COORD_BITS;
  localparam int LNGW = ANGLE_FRAC_BITS + 9;
  localparam int LATW = ANGLE_FRAC_BITS + 8;
  localparam int LAT  = 15 + DIV_STEPS + SQRT_STEPS + NORM_STEPS + 3 * CORDIC_STEPS;
  localparam int DSW  = 2 * AW + 2 + SQW;
  localparam int QSW  = 2 * AW + 2;
  localparam int RSW  = VW + RADIAL_BITS;
  localparam int V1SW = CW + RADIAL_BITS + 1;
  localparam int V2SW = 32 + RADIAL_BITS + 1;

  localparam logic signed [LNGW:0] DEG180 = (LNGW + 1)'(180) <<< ANGLE_FRAC_BITS;
  localparam logic signed [LNGW:0] DEG90  = (LNGW + 1)'(90) <<< ANGLE_FRAC_BITS;
  localparam logic [DEG_PROD_BITS-1:0] DEG_HALF =
    DEG_PROD_BITS'(1) << (31 - ANGLE_FRAC_BITS);

  // ---------------- configuration registers ----------------
  logic [RGW-1:0] frame_width;
  logic [RGW-1:0] frame_height;
  logic [RGW-1:0] globe_radius;
  logic [15:0]    sun_longitude;
  logic [15:0]    sun_latitude;
  logic           cfg_wr;
  logic [2:0]     cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width   <= RGW'(1024);
      frame_height  <= RGW'(1024);
      globe_radius  <= RGW'(400);
      sun_longitude <= '0;
      sun_latitude  <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_FRAME_WIDTH:  frame_width   <= pwdata[RGW-1:0];
        REG_FRAME_HEIGHT: frame_height  <= pwdata[RGW-1:0];
        REG_GLOBE_RADIUS: globe_radius  <= pwdata[RGW-1:0];
        REG_SUN_LON:      sun_longitude <= pwdata[15:0];
        REG_SUN_LAT:      sun_latitude  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_FRAME_WIDTH:  prdata = 32'(frame_width);
      REG_FRAME_HEIGHT: prdata = 32'(frame_height);
      REG_GLOBE_RADIUS: prdata = 32'(globe_radius);
      REG_SUN_LON:      prdata = 32'(sun_longitude);
      REG_SUN_LAT:      prdata = 32'(sun_latitude);
      default:          prdata = '0;
    endcase
  end

  // ---------------- pipeline control ----------------
  logic           adv;
  logic [LAT-1:0] vld;

  assign adv       = !out_valid || out_ready;
  assign in_ready  = adv;
  assign out_valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  // ---------------- centering ----------------
  logic signed [AW-1:0] s1_a, s1_b;
  logic [AW-1:0]        s1_d;
  logic [RGW-1:0]       r_eff;

  assign r_eff = (globe_radius == '0) ? RGW'(1) : globe_radius;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_a <= $signed(AW'(frame_width)) - $signed(AW'({pixel_x, 1'b0}));
      s1_b <= $signed(AW'(frame_height)) - $signed(AW'({pixel_y, 1'b0}));
      s1_d <= {r_eff, 1'b0};
    end
  end

  // ---------------- squares ----------------
  logic signed [2*AW-1:0] aa, bb;
  logic [SQW-1:0]         s2_s, s2_dd;
  logic signed [AW-1:0]   s2_a, s2_b;

  assign aa = s1_a * s1_a;
  assign bb = s1_b * s1_b;

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_s  <= SQW'(aa) + SQW'(bb);
      s2_dd <= s1_d * s1_d;
      s2_a  <= s1_a;
      s2_b  <= s1_b;
    end
  end

  // ---------------- disc test, divider setup ----------------
  logic [SQW-1:0]       dv_rem  [0:DIV_STEPS];
  logic [DIV_STEPS-1:0] dv_num  [0:DIV_STEPS];
  logic [DIV_STEPS-1:0] dv_q    [0:DIV_STEPS];
  logic [SQW-1:0]       dv_dd   [0:DIV_STEPS];
  logic [DSW-1:0]       dv_side [0:DIV_STEPS];
  logic [SQW-1:0]       s3_rem, s3_dd;
  logic [DIV_STEPS-1:0] s3_num;
  logic [DSW-1:0]       s3_side;

  always_ff @(posedge clk) begin
    if (adv) begin
      // Quotient s * 2^32 / dd needs 48 bits unless the radius saturates.
      s3_rem  <= s2_s >> 16;
      s3_num  <= {s2_s[15:0], 32'h0};
      s3_dd   <= s2_dd;
      s3_side <= {s2_a, s2_b, s2_s < s2_dd,
                  {16'h0, s2_s} >= {s2_dd, 16'h0}, SQW'(s2_dd - s2_s)};
    end
  end

  assign dv_rem[0]  = s3_rem;
  assign dv_num[0]  = s3_num;
  assign dv_q[0]    = '0;
  assign dv_dd[0]   = s3_dd;
  assign dv_side[0] = s3_side;

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    pgl_div_cell #(.DW(SQW), .SW(DSW)) u_cell (
      .clk      (clk),
      .en       (adv),
      .rem_in   (dv_rem[i]),
      .num_in   (dv_num[i]),
      .q_in     (dv_q[i]),
      .dd_in    (dv_dd[i]),
      .side_in  (dv_side[i]),
      .rem_out  (dv_rem[i+1]),
      .num_out  (dv_num[i+1]),
      .q_out    (dv_q[i+1]),
      .dd_out   (dv_dd[i+1]),
      .side_out (dv_side[i+1])
    );
  end

  // ---------------- shared square root ----------------
  logic [SQRT_RAD_BITS-1:0] sq_rad  [0:SQRT_STEPS];
  logic [SQRT_STEPS+1:0]    sq_rem  [0:SQRT_STEPS];
  logic [SQRT_STEPS-1:0]    sq_root [0:SQRT_STEPS];
  logic [QSW-1:0]           sq_side [0:SQRT_STEPS];
  logic [SQRT_RAD_BITS-1:0] s4_rad;
  logic [QSW-1:0]           s4_side;
  logic                     dv_on;
  logic [SQW-1:0]           dv_diff;

  assign dv_on   = dv_side[DIV_STEPS][SQW+1];
  assign dv_diff = dv_side[DIV_STEPS][SQW-1:0];

  // On the disc the root gives the depth, off it the radial distance.
  always_ff @(posedge clk) begin
    if (adv) begin
      s4_rad  <= dv_on ? (SQRT_RAD_BITS'(dv_diff) << (2 * SS))
                       : SQRT_RAD_BITS'(dv_q[DIV_STEPS]);
      s4_side <= dv_side[DIV_STEPS][DSW-1:SQW];
    end
  end

  assign sq_rad[0]  = s4_rad;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_side[0] = s4_side;

  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
    pgl_sqrt_cell #(.SW(QSW)) u_cell (
      .clk      (clk),
      .en       (adv),
      .rad_in   (sq_rad[i]),
      .rem_in   (sq_rem[i]),
      .root_in  (sq_root[i]),
      .side_in  (sq_side[i]),
      .rad_out  (sq_rad[i+1]),
      .rem_out  (sq_rem[i+1]),
      .root_out (sq_root[i+1]),
      .side_out (sq_side[i+1])
    );
  end

  // ---------------- vector assembly and normalization ----------------
  logic signed [AW-1:0]    sq_a, sq_b;
  logic                    sq_on, sq_sat;
  logic [SQRT_STEPS-1:0]   root;
  logic signed [VW-1:0]    s5_vx, s5_vy, s5_vz;
  logic [RADIAL_BITS-1:0]  s5_rad;
  logic [VW-2:0]           mx, my, mz, mxy;

  assign {sq_a, sq_b, sq_on, sq_sat} = sq_side[SQRT_STEPS];
  assign root = sq_root[SQRT_STEPS];

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_vx  <= VW'(sq_a) <<< SS;
      s5_vy  <= VW'(sq_b) <<< SS;
      s5_vz  <= sq_on ? -$signed({1'b0, root}) : '0;
      s5_rad <= sq_on ? RADIAL_ONE : (sq_sat ? RADIAL_MAX : root[RADIAL_BITS-1:0]);
    end
  end

  assign mx  = s5_vx[VW-1] ? (VW-1)'(-s5_vx) : s5_vx[VW-2:0];
  assign my  = s5_vy[VW-1] ? (VW-1)'(-s5_vy) : s5_vy[VW-2:0];
  assign mz  = s5_vz[VW-1] ? (VW-1)'(-s5_vz) : s5_vz[VW-2:0];
  assign mxy = (my > mx) ? my : mx;

  logic signed [VW-1:0]   nx  [0:NORM_STEPS];
  logic signed [VW-1:0]   ny  [0:NORM_STEPS];
  logic signed [VW-1:0]   nz  [0:NORM_STEPS];
  logic [VW-2:0]          nm  [0:NORM_STEPS];
  logic [RADIAL_BITS-1:0] nr  [0:NORM_STEPS];

  always_ff @(posedge clk) begin
    if (adv) begin
      nx[0] <= s5_vx;
      ny[0] <= s5_vy;
      nz[0] <= s5_vz;
      nm[0] <= (mz > mxy) ? mz : mxy;
      nr[0] <= s5_rad;
    end
  end

  // Binary search for the left shift that brings the largest magnitude to bit 28.
  for (genvar k = 0; k < NORM_STEPS; k++) begin : g_norm
    localparam int SH = 16 >> k;
    logic fits;
    assign fits = nm[k][VW-2 -: SH] == '0;
    always_ff @(posedge clk) begin
      if (adv) begin
        nx[k+1] <= fits ? (nx[k] <<< SH) : nx[k];
        ny[k+1] <= fits ? (ny[k] <<< SH) : ny[k];
        nz[k+1] <= fits ? (nz[k] <<< SH) : nz[k];
        nm[k+1] <= fits ? (nm[k] << SH) : nm[k];
        nr[k+1] <= nr[k];
      end
    end
  end

  // ---------------- tilt by the sun latitude ----------------
  logic signed [31:0]   th32, th_adj;
  logic                 th_big;
  logic signed [CW-1:0] rt_x [0:CORDIC_STEPS];
  logic signed [CW-1:0] rt_y [0:CORDIC_STEPS];
  logic signed [ZW-1:0] rt_z [0:CORDIC_STEPS];
  logic [RSW-1:0]       rt_s [0:CORDIC_STEPS];
  logic signed [CW-1:0] s6_x, s6_y;
  logic signed [ZW-1:0] s6_z;
  logic [RSW-1:0]       s6_s;

  assign th32   = $signed({sun_latitude, 16'h0});
  assign th_big = (th32 > $signed(TURN_QUARTER)) || (th32 < -$signed(TURN_QUARTER));
  assign th_adj = th_big ? $signed({~th32[31], th32[30:0]}) : th32;

  always_ff @(posedge clk) begin
    if (adv) begin
      s6_x <= th_big ? -CW'(ny[NORM_STEPS]) : CW'(ny[NORM_STEPS]);
      s6_y <= th_big ? -CW'(nz[NORM_STEPS]) : CW'(nz[NORM_STEPS]);
      s6_z <= ZW'(th_adj);
      s6_s <= {nx[NORM_STEPS], nr[NORM_STEPS]};
    end
  end

  assign rt_x[0] = s6_x;
  assign rt_y[0] = s6_y;
  assign rt_z[0] = s6_z;
  assign rt_s[0] = s6_s;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
    pgl_cordic_cell #(.STEP(i), .VECTOR(1'b0), .SW(RSW)) u_cell (
      .clk      (clk),
      .en       (adv),
      .x_in     (rt_x[i]),
      .y_in     (rt_y[i]),
      .z_in     (rt_z[i]),
      .side_in  (rt_s[i]),
      .x_out    (rt_x[i+1]),
      .y_out    (rt_y[i+1]),
      .z_out    (rt_z[i+1]),
      .side_out (rt_s[i+1])
    );
  end

  // ---------------- gain match of the untouched axis ----------------
  logic signed [VW-1:0]   rt_vx;
  logic [VW-2:0]          rt_vxm;
  logic [VW+30:0]         s7_prod;
  logic                   s7_neg;
  logic signed [CW-1:0]   s7_cx, s7_cy;
  logic [RADIAL_BITS-1:0] s7_rad;
  logic [VW+30:0]         s7_rnd;
  logic signed [CW-1:0]   s8_x, s8_y, s8_vy;
  logic [RADIAL_BITS-1:0] s8_rad;

  assign rt_vx  = rt_s[CORDIC_STEPS][RSW-1:RADIAL_BITS];
  assign rt_vxm = rt_vx[VW-1] ? (VW-1)'(-rt_vx) : rt_vx[VW-2:0];
  assign s7_rnd = (s7_prod + (VW+31)'(32'h2000_0000)) >> 30;

  always_ff @(posedge clk) begin
    if (adv) begin
      s7_prod <= (VW+31)'(rt_vxm) * (VW+31)'(G_Q30);
      s7_neg  <= rt_vx[VW-1];
      s7_cx   <= rt_x[CORDIC_STEPS];
      s7_cy   <= rt_y[CORDIC_STEPS];
      s7_rad  <= rt_s[CORDIC_STEPS][RADIAL_BITS-1:0];
      s8_x    <= s7_neg ? -$signed(CW'(s7_rnd)) : $signed(CW'(s7_rnd));
      s8_y    <= -s7_cy;
      s8_vy   <= s7_cx;
      s8_rad  <= s7_rad;
    end
  end

  // ---------------- longitude vectoring ----------------
  logic signed [CW-1:0] v1_x [0:CORDIC_STEPS];
  logic signed [CW-1:0] v1_y [0:CORDIC_STEPS];
  logic signed [ZW-1:0] v1_z [0:CORDIC_STEPS];
  logic [V1SW-1:0]      v1_s [0:CORDIC_STEPS];
  logic signed [CW-1:0] s9_x, s9_y;
  logic signed [ZW-1:0] s9_z;
  logic [V1SW-1:0]      s9_s;

  always_ff @(posedge clk) begin
    if (adv) begin
      s9_x <= s8_x[CW-1] ? -s8_x : s8_x;
      s9_y <= s8_x[CW-1] ? -s8_y : s8_y;
      s9_z <= s8_x[CW-1] ? Z_HALF : '0;
      s9_s <= {s8_vy, s8_rad, (s8_x == '0) && (s8_y == '0)};
    end
  end

  assign v1_x[0] = s9_x;
  assign v1_y[0] = s9_y;
  assign v1_z[0] = s9_z;
  assign v1_s[0] = s9_s;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_vec1
    pgl_cordic_cell #(.STEP(i), .VECTOR(1'b1), .SW(V1SW)) u_cell (
      .clk      (clk),
      .en       (adv),
      .x_in     (v1_x[i]),
      .y_in     (v1_y[i]),
      .z_in     (v1_z[i]),
      .side_in  (v1_s[i]),
      .x_out    (v1_x[i+1]),
      .y_out    (v1_y[i+1]),
      .z_out    (v1_z[i+1]),
      .side_out (v1_s[i+1])
    );
  end

  // ---------------- gain removal of the horizontal length ----------------
  logic                   v1_zero;
  logic [CW+29:0]         s10_prod;
  logic [31:0]            s10_alpha;
  logic signed [CW-1:0]   s10_vy;
  logic [RADIAL_BITS-1:0] s10_rad;
  logic [CW+29:0]         s10_rnd;
  logic signed [CW-1:0]   s11_h, s11_vy;
  logic [31:0]            s11_alpha;
  logic [RADIAL_BITS-1:0] s11_rad;

  assign v1_zero = v1_s[CORDIC_STEPS][0];
  assign s10_rnd = (s10_prod + (CW+30)'(32'h2000_0000)) >> 30;

  always_ff @(posedge clk) begin
    if (adv) begin
      s10_prod  <= v1_zero ? '0
                           : (CW+30)'(v1_x[CORDIC_STEPS][CW-2:0]) * (CW+30)'(K_Q30);
      s10_alpha <= v1_zero ? 32'h0 : v1_z[CORDIC_STEPS][31:0];
      s10_vy    <= v1_s[CORDIC_STEPS][V1SW-1 -: CW];
      s10_rad   <= v1_s[CORDIC_STEPS][RADIAL_BITS:1];
      s11_h     <= $signed(CW'(s10_rnd));
      s11_vy    <= s10_vy;
      s11_alpha <= s10_alpha;
      s11_rad   <= s10_rad;
    end
  end

  // ---------------- latitude vectoring ----------------
  logic signed [CW-1:0] v2_x [0:CORDIC_STEPS];
  logic signed [CW-1:0] v2_y [0:CORDIC_STEPS];
  logic signed [ZW-1:0] v2_z [0:CORDIC_STEPS];
  logic [V2SW-1:0]      v2_s [0:CORDIC_STEPS];
  logic signed [CW-1:0] s12_x, s12_y;
  logic signed [ZW-1:0] s12_z;
  logic [V2SW-1:0]      s12_s;

  always_ff @(posedge clk) begin
    if (adv) begin
      s12_x <= s11_h[CW-1] ? -s11_h : s11_h;
      s12_y <= s11_h[CW-1] ? -s11_vy : s11_vy;
      s12_z <= s11_h[CW-1] ? Z_HALF : '0;
      s12_s <= {s11_alpha, s11_rad, (s11_h == '0) && (s11_vy == '0)};
    end
  end

  assign v2_x[0] = s12_x;
  assign v2_y[0] = s12_y;
  assign v2_z[0] = s12_z;
  assign v2_s[0] = s12_s;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_vec2
    pgl_cordic_cell #(.STEP(i), .VECTOR(1'b1), .SW(V2SW)) u_cell (
      .clk      (clk),
      .en       (adv),
      .x_in     (v2_x[i]),
      .y_in     (v2_y[i]),
      .z_in     (v2_z[i]),
      .side_in  (v2_s[i]),
      .x_out    (v2_x[i+1]),
      .y_out    (v2_y[i+1]),
      .z_out    (v2_z[i+1]),
      .side_out (v2_s[i+1])
    );
  end

  // ---------------- conversion to degrees ----------------
  logic [31:0]              beta, lng_ang, ul, ub;
  logic [DEG_PROD_BITS-1:0] s13_pl, s13_pb;
  logic [RADIAL_BITS-1:0]   s13_rad;
  logic [LNGW-1:0]          rl, rb;
  logic signed [LNGW:0]     lngv, latv;

  assign beta    = v2_s[CORDIC_STEPS][0] ? 32'h0 : v2_z[CORDIC_STEPS][31:0];
  assign lng_ang = v2_s[CORDIC_STEPS][V2SW-1 -: 32] + {sun_longitude, 16'h0} - TURN_QUARTER;
  // Adding half a turn maps the signed angle onto an unsigned fraction of a turn.
  assign ul = {~lng_ang[31], lng_ang[30:0]};
  assign ub = {~beta[31], beta[30:0]};

  always_ff @(posedge clk) begin
    if (adv) begin
      s13_pl  <= DEG_PROD_BITS'(ul) * DEG_PROD_BITS'(360);
      s13_pb  <= DEG_PROD_BITS'(ub) * DEG_PROD_BITS'(360);
      s13_rad <= v2_s[CORDIC_STEPS][RADIAL_BITS:1];
    end
  end

  assign rl   = LNGW'((s13_pl + DEG_HALF) >> (32 - ANGLE_FRAC_BITS));
  assign rb   = LNGW'((s13_pb + DEG_HALF) >> (32 - ANGLE_FRAC_BITS));
  assign lngv = $signed({1'b0, rl}) - DEG180;
  assign latv = $signed({1'b0, rb}) - DEG180;

  always_ff @(posedge clk) begin
    if (adv) begin
      longitude       <= lngv[LNGW-1:0];
      radial_distance <= s13_rad;
      if (latv > DEG90) begin
        latitude <= DEG90[LATW-1:0];
      end else if (latv < -DEG90) begin
        latitude <= LATW'(-DEG90);
      end else begin
        latitude <= latv[LATW-1:0];
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_radial_floor: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> radial_distance >= RADIAL_ONE)
    else $error("radial distance below one globe radius");

  a_lat_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ($signed(latitude) <= $signed(DEG90[LATW-1:0]) &&
                   $signed(latitude) >= -$signed(DEG90[LATW-1:0])))
    else $error("latitude outside the clamp range");

  a_stall_holds_input: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("input taken while the pipeline is stalled");
`endif

endmodule
